### rtl/visibility_convolutional_gridder_defines.svh
// Assertion macros for the visibility convolutional gridder
`ifndef VISIBILITY_CONVOLUTIONAL_GRIDDER_DEFINES_SVH
`define VISIBILITY_CONVOLUTIONAL_GRIDDER_DEFINES_SVH
`define VCG_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define VCG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/vcg_pkg.sv
// Shared types and constants for the visibility convolutional gridder
`timescale 1ns / 1ps
package vcg_pkg;
  localparam int OVERSAMPLE = 8;
  localparam int KERNEL_SIDE = 16;
  localparam int MAX_GRID_SIDE = 512;
  localparam logic [1:0] FUNC_LOAD = 2'd0;
  localparam logic [1:0] FUNC_GRID = 2'd1;
  localparam logic [1:0] FUNC_READ = 2'd2;
  localparam logic CFG_UV_SCALE = 1'b0;
  localparam logic CFG_GRID_SIDE = 1'b1;
  localparam int ACC_W = 48;
  localparam int SKIP_W = 9;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PLACE,
    ST_SWEEP,
    ST_DRAIN,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clear_step;
    logic latch;
    logic place;
    logic sweep_start;
    logic sweep_step;
    logic read_issue;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic sweep_last;
    logic pipe_empty;
  } status_t;
endpackage

### rtl/vcg_ctrl.sv
// Controller state machine for the visibility convolutional gridder
`timescale 1ns / 1ps
`include "visibility_convolutional_gridder_defines.svh"
module vcg_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_func,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  vcg_pkg::status_t status,
  output vcg_pkg::cmd_t    cmd
);
  vcg_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic take;
  logic out_free;

  assign in_stall = (state_r != vcg_pkg::ST_IDLE);
  assign take = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      vcg_pkg::ST_CLEAR: if (status.clear_done) state_nxt = vcg_pkg::ST_IDLE;
      vcg_pkg::ST_IDLE: begin
        if (take) begin
          if (in_func == vcg_pkg::FUNC_GRID) state_nxt = vcg_pkg::ST_PLACE;
          else if (in_func == vcg_pkg::FUNC_READ) state_nxt = vcg_pkg::ST_READ;
          else state_nxt = vcg_pkg::ST_OUT;
        end
      end
      vcg_pkg::ST_PLACE: state_nxt = vcg_pkg::ST_SWEEP;
      vcg_pkg::ST_SWEEP: if (status.sweep_last) state_nxt = vcg_pkg::ST_DRAIN;
      vcg_pkg::ST_DRAIN: if (status.pipe_empty) state_nxt = vcg_pkg::ST_OUT;
      vcg_pkg::ST_READ: state_nxt = vcg_pkg::ST_OUT;
      vcg_pkg::ST_OUT: if (out_free) state_nxt = vcg_pkg::ST_IDLE;
      default: state_nxt = vcg_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      vcg_pkg::ST_CLEAR: cmd.clear_step = 1'b1;
      vcg_pkg::ST_IDLE: cmd.latch = take;
      vcg_pkg::ST_PLACE: begin
        cmd.place = 1'b1;
        cmd.sweep_start = 1'b1;
      end
      vcg_pkg::ST_SWEEP: cmd.sweep_step = 1'b1;
      vcg_pkg::ST_READ: cmd.read_issue = 1'b1;
      vcg_pkg::ST_OUT: cmd.out_load = out_free;
      default: cmd = '0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vcg_pkg::ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `VCG_ASSERT_IMPL(a_no_take_busy, clk, rst_n, state_r != vcg_pkg::ST_IDLE, in_stall)
  `VCG_ASSERT_NEXT(a_out_follows, clk, rst_n, cmd.out_load, out_valid_r)
  `VCG_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid_r && out_stall, out_valid_r)
  `VCG_ASSERT_IMPL(a_no_out_when_clear, clk, rst_n, state_r == vcg_pkg::ST_CLEAR, !out_valid_r)
endmodule

### rtl/vcg_datapath.sv
// Datapath for the visibility convolutional gridder: kernel table, grid, MAC pipe
`timescale 1ns / 1ps
`include "visibility_convolutional_gridder_defines.svh"
module vcg_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  vcg_pkg::cmd_t       cmd,
  output vcg_pkg::status_t    status,
  input  logic                cfg_valid,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_data,
  input  logic [1:0]          in_func,
  input  logic [13:0]         in_table_index,
  input  logic signed [15:0]  in_kernel_re,
  input  logic signed [15:0]  in_kernel_im,
  input  logic signed [31:0]  in_u_coord,
  input  logic signed [31:0]  in_v_coord,
  input  logic signed [15:0]  in_amp_re,
  input  logic signed [15:0]  in_amp_im,
  input  logic [8:0]          in_cell_row,
  input  logic [8:0]          in_cell_col,
  output logic signed [47:0]  out_cell_re,
  output logic signed [47:0]  out_cell_im,
  output logic [8:0]          out_skipped_cells
);
  localparam int OVERSAMPLE = vcg_pkg::OVERSAMPLE;
  localparam int KERNEL_SIDE = vcg_pkg::KERNEL_SIDE;
  localparam int MAX_GRID_SIDE = vcg_pkg::MAX_GRID_SIDE;
  localparam int GW = $clog2(MAX_GRID_SIDE);
  localparam int KW = $clog2(KERNEL_SIDE);
  localparam int PW = $clog2(OVERSAMPLE);
  localparam int TDEPTH = OVERSAMPLE * OVERSAMPLE * KERNEL_SIDE * KERNEL_SIDE;
  localparam int TW = $clog2(TDEPTH);
  localparam int GDEPTH = MAX_GRID_SIDE * MAX_GRID_SIDE;
  localparam int AW = 2 * GW;
  localparam int FW = 2 * KW;
  localparam int SW = GW + 1;
  localparam int OVS_MUL = OVERSAMPLE;

  logic [31:0] uv_scale_r;
  logic [9:0]  grid_side_r;
  logic [15:0] kre_mem [TDEPTH];
  logic [15:0] kim_mem [TDEPTH];
  logic [47:0] gre_mem [GDEPTH];
  logic [47:0] gim_mem [GDEPTH];

  logic [1:0]  func_r;
  logic [13:0] tidx_r;
  logic signed [15:0] kre_r, kim_r, are_r, aim_r;
  logic signed [31:0] u_r, v_r;
  logic [GW-1:0] row_r, col_r;

  logic [AW-1:0] clr_addr_r;
  logic signed [15:0] bu_r, bv_r;
  logic [PW-1:0] pu_r, pv_r;
  logic [SW-1:0] side_r;
  logic [FW-1:0] fp_r;
  logic [SW:0]  skip_r;
  logic signed [63:0] su, sv;
  logic [SW-1:0] side_sat;
  logic [15:0]  offs;

  // stage 1: address + table read
  logic          s1_v_r;
  logic [AW-1:0] s1_g_r;
  logic signed [15:0] s1_kr_r, s1_ki_r;
  // stage 2: products
  logic          s2_v_r;
  logic [AW-1:0] s2_g_r;
  logic signed [32:0] s2_pr_r, s2_pi_r;
  // stage 3: old grid value read
  logic          s3_v_r;
  logic [AW-1:0] s3_g_r;
  logic signed [32:0] s3_pr_r, s3_pi_r;
  logic [47:0] s3_ore_r, s3_oim_r;
  logic [47:0] rd_re_r, rd_im_r;

  logic signed [16:0] gr, gc;
  logic in_grid;
  logic [KW-1:0] fr, fc;
  logic [TW-1:0] kaddr;
  logic [AW-1:0] gaddr;
  logic [47:0] new_re, new_im;
  logic fwd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uv_scale_r <= 32'd65536;
      grid_side_r <= 10'd512;
    end else if (cfg_valid) begin
      if (cfg_index == vcg_pkg::CFG_UV_SCALE) uv_scale_r <= cfg_data;
      else grid_side_r <= cfg_data[9:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_func;
      tidx_r <= in_table_index;
      kre_r <= in_kernel_re;
      kim_r <= in_kernel_im;
      u_r <= in_u_coord;
      v_r <= in_v_coord;
      are_r <= in_amp_re;
      aim_r <= in_amp_im;
      row_r <= in_cell_row;
      col_r <= in_cell_col;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) clr_addr_r <= '0;
    else if (cmd.clear_step) clr_addr_r <= clr_addr_r + 1'b1;
  end
  assign status.clear_done = &clr_addr_r;

  always_ff @(posedge clk) begin
    if (func_r == vcg_pkg::FUNC_LOAD && cmd.out_load && 32'(tidx_r) < TDEPTH) begin
      kre_mem[tidx_r[TW-1:0]] <= kre_r;
      kim_mem[tidx_r[TW-1:0]] <= kim_r;
    end
  end

  always_comb begin
    if (grid_side_r < 10'd16) side_sat = SW'(16);
    else if (32'(grid_side_r) > MAX_GRID_SIDE) side_sat = SW'(MAX_GRID_SIDE);
    else side_sat = SW'(grid_side_r);
    offs = 16'(side_sat >> 1) - 16'(KERNEL_SIDE / 2);
    su = u_r * $signed({1'b0, uv_scale_r});
    sv = v_r * $signed({1'b0, uv_scale_r});
  end

  always_ff @(posedge clk) begin
    if (cmd.place) begin
      bu_r <= su[47:32] + offs;
      bv_r <= sv[47:32] + offs;
      pu_r <= PW'((36'(su[31:0]) * 36'(OVS_MUL)) >> 32);
      pv_r <= PW'((36'(sv[31:0]) * 36'(OVS_MUL)) >> 32);
      side_r <= side_sat;
    end
  end

  assign fr = fp_r[FW-1:KW];
  assign fc = fp_r[KW-1:0];
  assign gr = 17'(bu_r) + 17'(fr);
  assign gc = 17'(bv_r) + 17'(fc);
  assign in_grid = !gr[16] && !gc[16] && (gr < $signed(17'(side_r)))
                   && (gc < $signed(17'(side_r)));
  assign kaddr = TW'({pu_r, pv_r, fr, fc});
  assign gaddr = {gr[GW-1:0], gc[GW-1:0]};
  assign status.sweep_last = &fp_r;

  always_ff @(posedge clk) begin
    if (cmd.sweep_start) begin
      fp_r <= '0;
      skip_r <= '0;
    end else if (cmd.sweep_step) begin
      fp_r <= fp_r + 1'b1;
      if (!in_grid) skip_r <= skip_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= cmd.sweep_step && in_grid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_g_r <= gaddr;
    s1_kr_r <= kre_mem[kaddr];
    s1_ki_r <= kim_mem[kaddr];
    s2_g_r <= s1_g_r;
    s2_pr_r <= are_r * s1_kr_r - aim_r * s1_ki_r;
    s2_pi_r <= are_r * s1_ki_r + aim_r * s1_kr_r;
    s3_g_r <= s2_g_r;
    s3_pr_r <= s2_pr_r;
    s3_pi_r <= s2_pi_r;
    s3_ore_r <= gre_mem[s2_g_r];
    s3_oim_r <= gim_mem[s2_g_r];
    if (cmd.read_issue) begin
      rd_re_r <= gre_mem[{row_r, col_r}];
      rd_im_r <= gim_mem[{row_r, col_r}];
    end
  end

  assign status.pipe_empty = !s1_v_r && !s2_v_r && !s3_v_r;

  // forward when the stage 3 write hits the cell being read in stage 2
  assign fwd = s3_v_r && s2_v_r && (s3_g_r == s2_g_r);
  logic [47:0] wr_re_r, wr_im_r;
  logic [AW-1:0] wr_g_r;
  logic wr_v_r;
  always_comb begin
    new_re = s3_ore_r + 48'(s3_pr_r);
    new_im = s3_oim_r + 48'(s3_pi_r);
    if (wr_v_r && wr_g_r == s3_g_r) begin
      new_re = wr_re_r + 48'(s3_pr_r);
      new_im = wr_im_r + 48'(s3_pi_r);
    end
  end

  always_ff @(posedge clk) begin
    wr_v_r <= s3_v_r;
    wr_g_r <= s3_g_r;
    wr_re_r <= new_re;
    wr_im_r <= new_im;
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_step) begin
      gre_mem[clr_addr_r] <= '0;
      gim_mem[clr_addr_r] <= '0;
    end else if (s3_v_r) begin
      gre_mem[s3_g_r] <= new_re;
      gim_mem[s3_g_r] <= new_im;
    end else if (cmd.out_load && func_r == vcg_pkg::FUNC_READ) begin
      gre_mem[{row_r, col_r}] <= '0;
      gim_mem[{row_r, col_r}] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_cell_re <= '0;
      out_cell_im <= '0;
      out_skipped_cells <= '0;
      if (func_r == vcg_pkg::FUNC_READ) begin
        out_cell_re <= rd_re_r;
        out_cell_im <= rd_im_r;
      end else if (func_r == vcg_pkg::FUNC_GRID) begin
        out_skipped_cells <= 9'(skip_r);
      end
    end
  end

  `VCG_ASSERT_NEXT(a_pipe_flow, clk, rst_n, s1_v_r, s2_v_r)
  `VCG_ASSERT_IMPL(a_no_write_clear, clk, rst_n, cmd.clear_step, !s3_v_r)
  `VCG_ASSERT_IMPL(a_fwd_only_sweep, clk, rst_n, fwd, !cmd.out_load)
endmodule

### rtl/visibility_convolutional_gridder.sv
// Top level of the visibility convolutional gridder
// A kernel load or no-op goes straight to the result; a cell read first reads the grid
// cell, a visibility first places, sweeps and drains; a stalled result holds the block.
// One item is taken at a time; the sweep visits one footprint cell per cycle through a
// 3-stage MAC pipe.
// After reset a clearing pass zeroes the grid; no input is taken meanwhile, configuration
// writes are.
`timescale 1ns / 1ps
module visibility_convolutional_gridder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_func,
  input  logic [13:0]        in_table_index,
  input  logic signed [15:0] in_kernel_re,
  input  logic signed [15:0] in_kernel_im,
  input  logic signed [31:0] in_u_coord,
  input  logic signed [31:0] in_v_coord,
  input  logic signed [15:0] in_amp_re,
  input  logic signed [15:0] in_amp_im,
  input  logic [8:0]         in_cell_row,
  input  logic [8:0]         in_cell_col,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [47:0] out_cell_re,
  output logic signed [47:0] out_cell_im,
  output logic [8:0]         out_skipped_cells,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);
  vcg_pkg::cmd_t cmd;
  vcg_pkg::status_t status;

  assign cfg_ready = 1'b1;

  vcg_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_func(in_func),
    .in_stall(in_stall), .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .cmd(cmd)
  );

  vcg_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .status(status),
    .cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_func(in_func), .in_table_index(in_table_index),
    .in_kernel_re(in_kernel_re), .in_kernel_im(in_kernel_im),
    .in_u_coord(in_u_coord), .in_v_coord(in_v_coord),
    .in_amp_re(in_amp_re), .in_amp_im(in_amp_im),
    .in_cell_row(in_cell_row), .in_cell_col(in_cell_col),
    .out_cell_re(out_cell_re), .out_cell_im(out_cell_im),
    .out_skipped_cells(out_skipped_cells)
  );
endmodule

### tb/sv/tb.sv
// Testbench for the visibility convolutional gridder: predicts and checks every result
`timescale 1ns / 1ps
module tb;
  localparam int OVS = vcg_pkg::OVERSAMPLE;
  localparam int KSIDE = vcg_pkg::KERNEL_SIDE;
  localparam int GMAX = vcg_pkg::MAX_GRID_SIDE;
  localparam int TDEPTH = OVS * OVS * KSIDE * KSIDE;
  localparam logic [1:0] FUNC_NONE = 2'd3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] in_func = '0;
  logic [13:0] in_table_index = '0;
  logic signed [15:0] in_kernel_re = '0;
  logic signed [15:0] in_kernel_im = '0;
  logic signed [31:0] in_u_coord = '0;
  logic signed [31:0] in_v_coord = '0;
  logic signed [15:0] in_amp_re = '0;
  logic signed [15:0] in_amp_im = '0;
  logic [8:0] in_cell_row = '0;
  logic [8:0] in_cell_col = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [47:0] out_cell_re;
  logic signed [47:0] out_cell_im;
  logic [8:0] out_skipped_cells;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_index = 1'b0;
  logic [31:0] cfg_data = '0;

  typedef struct packed {
    logic [47:0] re;
    logic [47:0] im;
    logic [8:0] skipped;
  } cell_result_t;

  typedef struct packed {
    logic [1:0] func;
    logic [13:0] tidx;
    logic [15:0] kre;
    logic [15:0] kim;
    logic [31:0] u;
    logic [31:0] v;
    logic [15:0] are;
    logic [15:0] aim;
    logic [8:0] row;
    logic [8:0] col;
  } vis_item_t;

  logic [15:0] ktab_re [TDEPTH];
  logic [15:0] ktab_im [TDEPTH];
  logic [47:0] grid_re [int];
  logic [47:0] grid_im [int];
  logic [31:0] scale_q;
  logic [9:0] side_q;
  cell_result_t expected_cells[$];
  int errors = 0;
  bit quiet_in = 0;
  bit quiet_out = 0;

  visibility_convolutional_gridder u_dut (.*);

  always #2 clk = ~clk;

  initial begin
    #80ms;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int place_axis(logic [31:0] coord, int offset, output int plane);
    logic signed [63:0] prod;
    logic [15:0] base;
    prod = $signed(coord) * $signed({1'b0, scale_q});
    plane = int'(prod[31:29]);
    base = prod[47:32] + offset[15:0];
    return $signed(base);
  endfunction

  function automatic cell_result_t grid_predict(vis_item_t it);
    cell_result_t res;
    int side, offset, bu, bv, pu, pv, gr, gc, k, g;
    logic signed [47:0] pr, pi;
    res = '0;
    case (it.func)
      vcg_pkg::FUNC_LOAD: begin
        ktab_re[it.tidx] = it.kre;
        ktab_im[it.tidx] = it.kim;
      end
      vcg_pkg::FUNC_GRID: begin
        side = int'(side_q);
        if (side < 16) side = 16;
        if (side > GMAX) side = GMAX;
        offset = side / 2 - KSIDE / 2;
        bu = place_axis(it.u, offset, pu);
        bv = place_axis(it.v, offset, pv);
        for (int r = 0; r < KSIDE; r++)
          for (int c = 0; c < KSIDE; c++) begin
            gr = bu + r;
            gc = bv + c;
            if (gr < 0 || gr >= side || gc < 0 || gc >= side) begin
              res.skipped++;
              continue;
            end
            k = ((pu * OVS + pv) * KSIDE + r) * KSIDE + c;
            pr = $signed(it.are) * $signed(ktab_re[k]) - $signed(it.aim) * $signed(ktab_im[k]);
            pi = $signed(it.are) * $signed(ktab_im[k]) + $signed(it.aim) * $signed(ktab_re[k]);
            g = gr * GMAX + gc;
            if (!grid_re.exists(g)) begin
              grid_re[g] = '0;
              grid_im[g] = '0;
            end
            grid_re[g] += pr;
            grid_im[g] += pi;
          end
      end
      vcg_pkg::FUNC_READ: begin
        g = it.row * GMAX + it.col;
        if (grid_re.exists(g)) begin
          res.re = grid_re[g];
          res.im = grid_im[g];
          grid_re.delete(g);
          grid_im.delete(g);
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  always @(posedge clk) begin
    cell_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("unexpected transfer", out_cell_re, '0);
      end else begin
        want = expected_cells.pop_front();
        if (out_cell_re !== want.re) report_mismatch("cell_re", out_cell_re, want.re);
        if (out_cell_im !== want.im) report_mismatch("cell_im", out_cell_im, want.im);
        if (out_skipped_cells !== want.skipped)
          report_mismatch("skipped_cells", 48'(out_skipped_cells), 48'(want.skipped));
      end
    end
    out_stall <= quiet_out ? 1'b0 : ($urandom_range(99) < 23);
  end

  task automatic send_item(vis_item_t it);
    @(posedge clk);
    while (!quiet_in && $urandom_range(99) < 23) @(posedge clk);
    in_valid <= 1'b1;
    in_func <= it.func;
    in_table_index <= it.tidx;
    in_kernel_re <= it.kre;
    in_kernel_im <= it.kim;
    in_u_coord <= it.u;
    in_v_coord <= it.v;
    in_amp_re <= it.are;
    in_amp_im <= it.aim;
    in_cell_row <= it.row;
    in_cell_col <= it.col;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_cells.push_back(grid_predict(it));
    in_valid <= 1'b0;
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    while (expected_cells.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == vcg_pkg::CFG_UV_SCALE) scale_q = data;
    else side_q = data[9:0];
  endtask

  function automatic vis_item_t rand_item(logic [1:0] func);
    vis_item_t it;
    it.func = func;
    it.tidx = 14'($urandom);
    it.kre = 16'($urandom);
    it.kim = 16'($urandom);
    it.u = $urandom;
    it.v = $urandom;
    it.are = 16'($urandom);
    it.aim = 16'($urandom);
    it.row = 9'($urandom);
    it.col = 9'($urandom);
    return it;
  endfunction

  function automatic vis_item_t near_vis(int span);
    vis_item_t it;
    it = rand_item(vcg_pkg::FUNC_GRID);
    it.u = $signed($urandom_range(2 * span)) - span;
    it.u = {it.u[15:0], 16'h0} | $urandom_range(16'hffff);
    it.v = $signed($urandom_range(2 * span)) - span;
    it.v = {it.v[15:0], 16'h0} | $urandom_range(16'hffff);
    return it;
  endfunction

  function automatic vis_item_t read_near(int span);
    vis_item_t it;
    int mid;
    it = rand_item(vcg_pkg::FUNC_READ);
    mid = int'(side_q < 10'd16 ? 10'd16 : side_q) / 2;
    it.row = 9'(mid - span + int'($urandom_range(2 * span)));
    it.col = 9'(mid - span + int'($urandom_range(2 * span)));
    return it;
  endfunction

  task automatic test_kernel_load();
    vis_item_t it;
    for (int i = 0; i < TDEPTH; i++) begin
      it = rand_item(vcg_pkg::FUNC_LOAD);
      it.tidx = 14'(i);
      if (i == 0) begin it.kre = 16'h8000; it.kim = 16'h7fff; end
      if (i == 1) begin it.kre = 16'h7fff; it.kim = 16'h8000; end
      if (i == 2) begin it.kre = 16'h8000; it.kim = 16'h8000; end
      send_item(it);
      if (i == 2000) quiet_in = 1;
    end
    quiet_in = 0;
  endtask

  task automatic test_directed();
    vis_item_t it;
    it = rand_item(vcg_pkg::FUNC_GRID);
    it.u = 32'd0; it.v = 32'd0; it.are = 16'h8000; it.aim = 16'h8000;
    send_item(it);
    it.u = 32'h7fffffff; it.v = 32'h80000000; it.are = 16'h7fff; it.aim = 16'h7fff;
    send_item(it);
    it.u = 32'hfff80000; it.v = 32'h00f00000;
    send_item(it);
    it = rand_item(vcg_pkg::FUNC_READ);
    it.row = 9'd256; it.col = 9'd256; send_item(it);
    it.row = 9'd511; it.col = 9'd0; send_item(it);
    it.row = 9'd0; it.col = 9'd511; send_item(it);
    it = rand_item(FUNC_NONE);
    send_item(it);
    repeat (2) begin
      it = rand_item(vcg_pkg::FUNC_LOAD);
      it.tidx = 14'(TDEPTH - 1);
      send_item(it);
    end
    for (int i = 0; i < 10; i++) begin
      send_item(near_vis(4));
      send_item(read_near(10));
    end
    wait_idle();
  endtask

  task automatic test_random(int count);
    int f;
    for (int i = 0; i < count; i++) begin
      quiet_in = (i >= count / 2) && (i < count / 2 + 150);
      quiet_out = quiet_in;
      f = $urandom_range(99);
      if (f < 45) send_item(near_vis(12));
      else if (f < 85) send_item(read_near(14));
      else if (f < 92) send_item(rand_item(vcg_pkg::FUNC_GRID));
      else if (f < 96) send_item(rand_item(vcg_pkg::FUNC_LOAD));
      else if (f < 98) send_item(rand_item(FUNC_NONE));
      else send_item(rand_item(vcg_pkg::FUNC_READ));
    end
    quiet_in = 0;
    quiet_out = 0;
    wait_idle();
  endtask

  task automatic test_config_sweep();
    write_reg(vcg_pkg::CFG_GRID_SIDE, 32'd16);
    write_reg(vcg_pkg::CFG_UV_SCALE, 32'h0000_4000);
    test_random(300);
    write_reg(vcg_pkg::CFG_GRID_SIDE, 32'd0);
    write_reg(vcg_pkg::CFG_UV_SCALE, 32'hffff_ffff);
    test_random(150);
    write_reg(vcg_pkg::CFG_GRID_SIDE, 32'h3ff);
    write_reg(vcg_pkg::CFG_UV_SCALE, 32'h0);
    test_random(150);
    write_reg(vcg_pkg::CFG_GRID_SIDE, 32'd100);
    write_reg(vcg_pkg::CFG_UV_SCALE, 32'h0003_8000);
    test_random(300);
    write_reg(vcg_pkg::CFG_GRID_SIDE, 32'd512);
    write_reg(vcg_pkg::CFG_UV_SCALE, 32'h0001_0000);
  endtask

  initial begin
    scale_q = 32'h0001_0000;
    side_q = 10'd512;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    write_reg(vcg_pkg::CFG_GRID_SIDE, 32'd512);
    test_kernel_load();
    wait_idle();
    test_directed();
    test_random(600);
    test_config_sweep();
    test_random(300);
    if (expected_cells.size() != 0) errors++;
    if (errors == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end
endmodule
